FILE: rtl/rhrb_pkg.sv
// Shared types and constants for the replay history ring buffer.
package rhrb_pkg;

    localparam int unsigned RHRB_DEPTH_DEF = 65536;
    localparam int unsigned OFF_W          = 63;
    localparam int unsigned OP_W           = 2;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned IN_W           = 80;

    localparam logic [OP_W-1:0] OP_APPEND  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_DISCARD = 2'd2;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic rd_issue;
        logic load_out;
    } rhrb_cmd_t;

    typedef struct packed {
        logic op_is_read;
    } rhrb_status_t;

endpackage

FILE: rtl/replay_history_ring_buffer_unit.sv
// Top level of the replay history ring buffer: stream ports, controller and datapath.
//
// Keeps the last BUFFER_DEPTH bytes of a byte stream in a single-port RAM and
// addresses them by absolute stream offset. Each input transfer is an append,
// a read at an offset, or a discard, and yields exactly one result transfer
// carrying the read byte, the hit flag, the running stream offset, the first
// held offset and the held length after the operation. One item is in flight
// at a time: each item, unused codes included, passes from the input registers
// through the execute step to the output register, and a read adds an address
// step for the registered read of the history RAM. The result waits in the done
// state while the output register holds an untaken result, and the next input
// transfer is taken in the cycle after the output register is loaded.
module replay_history_ring_buffer_unit #(
    parameter int unsigned BUFFER_DEPTH = rhrb_pkg::RHRB_DEPTH_DEF,
    localparam int unsigned LEN_W       = $clog2(BUFFER_DEPTH + 1),
    localparam int unsigned RES_W       = 2 * rhrb_pkg::OFF_W + rhrb_pkg::BYTE_W + 1 + LEN_W,
    localparam int unsigned OUT_W       = ((RES_W + 7) / 8) * 8
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // operation[1:0], data_byte[9:2], read_offset[72:10], zero pad
    input  logic [rhrb_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // read_byte, hit, stream_offset, first_offset, held_length, zero pad
    output logic [OUT_W-1:0]           m_tdata
);
    import rhrb_pkg::*;

    rhrb_cmd_t         cmd;
    rhrb_status_t      status;
    logic [BYTE_W-1:0] read_byte;
    logic              hit;
    logic [OFF_W-1:0]  stream_offset;
    logic [OFF_W-1:0]  first_offset;
    logic [LEN_W-1:0]  held_length;

    rhrb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rhrb_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .in_operation      (s_tdata[OP_W-1:0]),
        .in_data_byte      (s_tdata[OP_W+BYTE_W-1:OP_W]),
        .in_read_offset    (s_tdata[OP_W+BYTE_W+OFF_W-1:OP_W+BYTE_W]),
        .out_read_byte     (read_byte),
        .out_hit           (hit),
        .out_stream_offset (stream_offset),
        .out_first_offset  (first_offset),
        .out_held_length   (held_length)
    );

    assign m_tdata = OUT_W'({held_length, first_offset, stream_offset, hit, read_byte});

endmodule

FILE: rtl/rhrb_ram.sv
// Generic single-port RAM with registered read data.
module rhrb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rhrb_ctrl.sv
// Controller state machine for the replay history ring buffer.
module rhrb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  rhrb_pkg::rhrb_status_t status,
    output rhrb_pkg::rhrb_cmd_t    cmd
);
    import rhrb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ADDR,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd          = '0;
        cmd.load_in  = (state_reg == ST_IDLE) && s_tvalid;
        cmd.exec     = (state_reg == ST_EXEC);
        cmd.rd_issue = (state_reg == ST_ADDR);
        cmd.load_out = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    state_reg <= status.op_is_read ? ST_ADDR : ST_DONE;
                end
                ST_ADDR: begin
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

FILE: rtl/rhrb_datapath.sv
// Datapath: offset registers, window test, ring index arithmetic and history RAM.
module rhrb_datapath #(
    parameter int unsigned BUFFER_DEPTH = rhrb_pkg::RHRB_DEPTH_DEF,
    localparam int unsigned LEN_W       = $clog2(BUFFER_DEPTH + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rhrb_pkg::rhrb_cmd_t          cmd,
    output rhrb_pkg::rhrb_status_t       status,
    input  logic [rhrb_pkg::OP_W-1:0]    in_operation,
    input  logic [rhrb_pkg::BYTE_W-1:0]  in_data_byte,
    input  logic [rhrb_pkg::OFF_W-1:0]   in_read_offset,
    output logic [rhrb_pkg::BYTE_W-1:0]  out_read_byte,
    output logic                         out_hit,
    output logic [rhrb_pkg::OFF_W-1:0]   out_stream_offset,
    output logic [rhrb_pkg::OFF_W-1:0]   out_first_offset,
    output logic [LEN_W-1:0]             out_held_length
);
    import rhrb_pkg::*;

    localparam int unsigned IDX_W = $clog2(BUFFER_DEPTH);
    localparam int unsigned SUM_W = LEN_W + 1;

    logic [OP_W-1:0]   op_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [OFF_W-1:0]  req_reg;

    logic [IDX_W-1:0]  wi_reg;
    logic [LEN_W-1:0]  cnt_reg;
    logic [OFF_W-1:0]  run_reg;
    logic [OFF_W-1:0]  old_reg;

    logic              hit_reg;
    logic [IDX_W-1:0]  skip_reg;
    logic [LEN_W-1:0]  base_reg;

    logic [BYTE_W-1:0] rbyte_out_reg;
    logic              hit_out_reg;
    logic [OFF_W-1:0]  run_out_reg;
    logic [OFF_W-1:0]  old_out_reg;
    logic [LEN_W-1:0]  cnt_out_reg;

    logic [LEN_W-1:0]  cnt_next;
    logic [OFF_W-1:0]  run_next;
    logic [IDX_W-1:0]  wi_next;
    logic [OFF_W-1:0]  skip_full;
    logic              hit_next;
    logic [LEN_W-1:0]  base_next;
    logic [SUM_W-1:0]  addr_sum;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  ram_addr;
    logic              ram_we;
    logic [BYTE_W-1:0] ram_q;

    assign cnt_next = (cnt_reg < LEN_W'(BUFFER_DEPTH)) ? cnt_reg + 1'b1 : cnt_reg;
    assign run_next = run_reg + 1'b1;
    assign wi_next  = (wi_reg == IDX_W'(BUFFER_DEPTH - 1)) ? '0 : wi_reg + 1'b1;

    assign skip_full = req_reg - old_reg;
    assign hit_next  = skip_full < OFF_W'(cnt_reg);
    assign base_next = ({1'b0, wi_reg} >= cnt_reg)
                     ? LEN_W'({1'b0, wi_reg}) - cnt_reg
                     : LEN_W'({1'b0, wi_reg}) + LEN_W'(BUFFER_DEPTH) - cnt_reg;

    assign addr_sum = SUM_W'(base_reg) + SUM_W'(skip_reg);
    assign rd_addr  = (addr_sum >= SUM_W'(BUFFER_DEPTH))
                    ? IDX_W'(addr_sum - SUM_W'(BUFFER_DEPTH))
                    : IDX_W'(addr_sum);

    assign ram_we   = cmd.exec && (op_reg == OP_APPEND);
    assign ram_addr = ram_we ? wi_reg : rd_addr;

    rhrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_history (
        .aclk  (aclk),
        .we    (ram_we),
        .re    (cmd.rd_issue),
        .addr  (ram_addr),
        .wdata (byte_reg),
        .rdata (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg   <= in_operation;
            byte_reg <= in_data_byte;
            req_reg  <= in_read_offset;
        end
        if (cmd.exec) begin
            hit_reg  <= (op_reg == OP_READ) && hit_next;
            skip_reg <= skip_full[IDX_W-1:0];
            base_reg <= base_next;
        end
        if (cmd.load_out) begin
            rbyte_out_reg <= hit_reg ? ram_q : '0;
            hit_out_reg   <= hit_reg;
            run_out_reg   <= run_reg;
            old_out_reg   <= old_reg;
            cnt_out_reg   <= cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wi_reg  <= '0;
            cnt_reg <= '0;
            run_reg <= '0;
            old_reg <= OFF_W'(1);
        end else if (cmd.exec) begin
            case (op_reg)
                OP_APPEND: begin
                    wi_reg  <= wi_next;
                    cnt_reg <= cnt_next;
                    run_reg <= run_next;
                    old_reg <= run_reg + OFF_W'(2) - OFF_W'(cnt_next);
                end
                OP_DISCARD: begin
                    wi_reg  <= '0;
                    cnt_reg <= '0;
                    old_reg <= run_next;
                end
                default: begin
                end
            endcase
        end
    end

    assign status.op_is_read = (op_reg == OP_READ);

    assign out_read_byte     = rbyte_out_reg;
    assign out_hit           = hit_out_reg;
    assign out_stream_offset = run_out_reg;
    assign out_first_offset  = old_out_reg;
    assign out_held_length   = cnt_out_reg;

endmodule

FILE: test/replay_history_ring_buffer_unit_tb.sv
// Self-checking testbench for the replay history ring buffer top level.
module replay_history_ring_buffer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rhrb_pkg::*;

    localparam int unsigned DEPTH          = RHRB_DEPTH_DEF;
    localparam int unsigned IDX_W          = $clog2(DEPTH);
    localparam int unsigned LEN_W          = $clog2(DEPTH + 1);
    localparam int unsigned RES_W          = 2 * OFF_W + BYTE_W + 1 + LEN_W;
    localparam int unsigned OUT_W          = ((RES_W + 7) / 8) * 8;
    localparam int unsigned PAD_W          = IN_W - OP_W - BYTE_W - OFF_W;
    localparam int unsigned RAND_PER_PHASE = 140;
    localparam int unsigned FILL_ITEMS     = 40;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam int unsigned MAX_REPORTS    = 40;

    localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
    localparam logic [OFF_W-1:0] OFF_MAX   = {OFF_W{1'b1}};

    // read_byte lands in the low bits of m_tdata
    typedef struct packed {
        logic [LEN_W-1:0]  held_length;
        logic [OFF_W-1:0]  first_offset;
        logic [OFF_W-1:0]  stream_offset;
        logic              hit;
        logic [BYTE_W-1:0] read_byte;
    } result_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] data;
        logic [OFF_W-1:0]  offset;
        logic              has_want;
        result_t           want;
    } row_t;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    // predictor state
    logic [BYTE_W-1:0] hist_mem [DEPTH];
    logic [IDX_W-1:0]  wr_ptr     = '0;
    logic [LEN_W-1:0]  held_cnt   = '0;
    logic [OFF_W-1:0]  run_off    = '0;
    logic [OFF_W-1:0]  oldest_off = OFF_W'(1);

    result_t     pending_results [$];
    int unsigned src_idle       = 16;
    int unsigned snk_idle       = 70;
    int unsigned mismatch_count = 0;
    int unsigned items_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned read_count     = 0;
    int unsigned hit_count      = 0;
    int unsigned discard_count  = 0;
    int unsigned peak_held      = 0;
    int unsigned idle_cycles    = 0;

    // want: held_length, first_offset, stream_offset, hit, read_byte
    row_t directed_rows [23] = '{
        '{OP_READ,    8'h00, 63'd0,   1'b1, '{17'd0, 63'd1, 63'd0, 1'b0, 8'h00}},
        '{OP_READ,    8'h00, OFF_MAX, 1'b1, '{17'd0, 63'd1, 63'd0, 1'b0, 8'h00}},
        '{OP_DISCARD, 8'h00, 63'd0,   1'b1, '{17'd0, 63'd1, 63'd0, 1'b0, 8'h00}},
        '{OP_UNUSED,  8'hFF, OFF_MAX, 1'b1, '{17'd0, 63'd1, 63'd0, 1'b0, 8'h00}},
        '{OP_APPEND,  8'h00, 63'd0,   1'b1, '{17'd1, 63'd1, 63'd1, 1'b0, 8'h00}},
        '{OP_APPEND,  8'hFF, OFF_MAX, 1'b1, '{17'd2, 63'd1, 63'd2, 1'b0, 8'h00}},
        '{OP_READ,    8'hFF, 63'd1,   1'b1, '{17'd2, 63'd1, 63'd2, 1'b1, 8'h00}},
        '{OP_READ,    8'h00, 63'd2,   1'b1, '{17'd2, 63'd1, 63'd2, 1'b1, 8'hFF}},
        '{OP_READ,    8'h00, 63'd3,   1'b1, '{17'd2, 63'd1, 63'd2, 1'b0, 8'h00}},
        '{OP_READ,    8'h00, 63'd0,   1'b1, '{17'd2, 63'd1, 63'd2, 1'b0, 8'h00}},
        '{OP_READ,    8'h00, OFF_MAX, 1'b1, '{17'd2, 63'd1, 63'd2, 1'b0, 8'h00}},
        '{OP_DISCARD, 8'hFF, OFF_MAX, 1'b1, '{17'd0, 63'd3, 63'd2, 1'b0, 8'h00}},
        '{OP_READ,    8'h00, 63'd2,   1'b1, '{17'd0, 63'd3, 63'd2, 1'b0, 8'h00}},
        '{OP_APPEND,  8'hA5, 63'd0,   1'b1, '{17'd1, 63'd3, 63'd3, 1'b0, 8'h00}},
        '{OP_READ,    8'h00, 63'd3,   1'b1, '{17'd1, 63'd3, 63'd3, 1'b1, 8'hA5}},
        '{OP_UNUSED,  8'hFF, OFF_MAX, 1'b1, '{17'd1, 63'd3, 63'd3, 1'b0, 8'h00}},
        '{OP_APPEND,  8'h5A, OFF_MAX, 1'b0, '0},
        '{OP_APPEND,  8'h81, 63'd0,   1'b0, '0},
        '{OP_READ,    8'h00, 63'd4,   1'b0, '0},
        '{OP_READ,    8'h00, 63'd5,   1'b0, '0},
        '{OP_READ,    8'h00, 63'd6,   1'b0, '0},
        '{OP_DISCARD, 8'hFF, OFF_MAX, 1'b0, '0},
        '{OP_READ,    8'h00, 63'd5,   1'b0, '0}
    };

    replay_history_ring_buffer_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic result_t ring_predict(input logic [OP_W-1:0] op,
                                             input logic [BYTE_W-1:0] data,
                                             input logic [OFF_W-1:0] offset);
        result_t          r;
        logic [OFF_W-1:0] skip;
        logic [IDX_W-1:0] idx;
        r = '0;
        case (op)
            OP_APPEND: begin
                hist_mem[wr_ptr] = data;
                wr_ptr = wr_ptr + 1'b1;
                if (held_cnt < DEPTH) held_cnt = held_cnt + 1'b1;
                run_off    = run_off + 1'b1;
                oldest_off = run_off - held_cnt + 1'b1;
                if (held_cnt > peak_held) peak_held = held_cnt;
            end
            OP_READ: begin
                read_count++;
                skip = offset - oldest_off;
                if (skip < held_cnt) begin
                    idx = wr_ptr - held_cnt[IDX_W-1:0] + skip[IDX_W-1:0];
                    r.read_byte = hist_mem[idx];
                    r.hit       = 1'b1;
                    hit_count++;
                end
            end
            OP_DISCARD: begin
                discard_count++;
                wr_ptr     = '0;
                held_cnt   = '0;
                oldest_off = run_off + 1'b1;
            end
            default: ;
        endcase
        r.stream_offset = run_off;
        r.first_offset  = oldest_off;
        r.held_length   = held_cnt;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t, result %0d, %s: got 0x%0h, expected 0x%0h",
                     $time, results_seen, field, got, want);
    endtask

    // valid stays high across back-to-back items; only a gap lowers it
    task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                             input logic [OFF_W-1:0] offset, input logic has_want,
                             input result_t want);
        result_t predicted;
        if ($urandom_range(0, 99) < src_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, offset, data, op};
        do @(posedge aclk); while (!s_tready);
        predicted = ring_predict(op, data, offset);
        pending_results.push_back(has_want ? want : predicted);
        items_sent++;
    endtask

    task automatic send_random_item();
        int unsigned      pick;
        int unsigned      span;
        logic [OFF_W-1:0] offset;
        logic [BYTE_W-1:0] data;
        pick   = $urandom_range(0, 99);
        offset = OFF_W'({$urandom, $urandom});
        data   = BYTE_W'($urandom);
        if (pick < 45) begin
            send_item(OP_APPEND, data, offset, 1'b0, '0);
        end else if (pick < 80) begin
            // mostly in or next to the held window, including one past each end
            span = $urandom_range(0, 9);
            if (span == 0)
                offset = oldest_off - 1'b1;
            else if (span < 8)
                offset = oldest_off + OFF_W'($urandom_range(0, held_cnt));
            send_item(OP_READ, data, offset, 1'b0, '0);
        end else if (pick < 88) begin
            send_item(OP_DISCARD, data, offset, 1'b0, '0);
        end else if (pick < 94) begin
            send_item(OP_UNUSED, data, offset, 1'b0, '0);
        end else begin
            send_item(OP_READ, data, offset, 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_idle);
    end

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[RES_W-1:0]);
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result transfer", '0, '0);
            end else begin
                want = pending_results.pop_front();
                if (got.read_byte !== want.read_byte)
                    report_mismatch("read_byte", got.read_byte, want.read_byte);
                if (got.hit !== want.hit)
                    report_mismatch("hit", got.hit, want.hit);
                if (got.stream_offset !== want.stream_offset)
                    report_mismatch("stream_offset", got.stream_offset, want.stream_offset);
                if (got.first_offset !== want.first_offset)
                    report_mismatch("first_offset", got.first_offset, want.first_offset);
                if (got.held_length !== want.held_length)
                    report_mismatch("held_length", got.held_length, want.held_length);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned phase;
        int unsigned n;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].offset,
                      directed_rows[i].has_want, directed_rows[i].want);

        for (phase = 0; phase < 3; phase++) begin
            src_idle = (phase == 0) ? 16 : (phase == 1) ? 70 : 0;
            snk_idle = (phase == 0) ? 70 : (phase == 1) ? 16 : 0;
            for (n = 0; n < RAND_PER_PHASE; n++)
                send_random_item();
            // drain before the next phase
            s_tvalid <= 1'b0;
            do @(posedge aclk); while (pending_results.size() != 0);
        end

        // fill a fresh history, with reads sprinkled in
        send_item(OP_DISCARD, 8'h00, 63'd0, 1'b0, '0);
        for (n = 0; n < FILL_ITEMS; n++) begin
            if (n % 7 == 6)
                send_item(OP_READ, 8'h00,
                          oldest_off + OFF_W'($urandom_range(0, held_cnt - 1)), 1'b0, '0);
            else
                send_item(OP_APPEND, BYTE_W'($urandom), OFF_W'({$urandom, $urandom}),
                          1'b0, '0);
        end
        for (n = 0; n < 40; n++) begin
            case (n % 5)
                0: send_item(OP_READ, 8'h00, oldest_off - 1'b1, 1'b0, '0);
                1: send_item(OP_READ, 8'h00, oldest_off, 1'b0, '0);
                2: send_item(OP_READ, 8'h00, run_off, 1'b0, '0);
                3: send_item(OP_READ, 8'h00, run_off + 1'b1, 1'b0, '0);
                default: send_item(OP_READ, 8'h00,
                                   oldest_off + OFF_W'($urandom_range(0, held_cnt - 1)),
                                   1'b0, '0);
            endcase
        end

        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Ran %0d items: %0d reads (%0d hits), %0d discards, peak history %0d bytes",
                 items_sent, read_count, hit_count, discard_count, peak_held);
        $display("Back-pressure on both sides, drained pauses and reads at both window edges");
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule
